>>> design/apknn_pkg.sv
// ============================================================================
// apknn_pkg
// Shared types and constants for the all-points k-nearest-neighbor block.
// ============================================================================
package apknn_pkg;

    localparam int COORD_W = 16;
    localparam int DSQ_W   = 34;   // 3 * (2^16-1)^2 < 2^34
    localparam int DIST_W  = 17;
    localparam int IDX_W   = 7;
    localparam int RANK_W  = 3;
    localparam int CNT_W   = 8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   point_index;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  neighbor_index;
        logic [DIST_W-1:0] distance;
        logic [RANK_W-1:0] rank;
        logic              last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOADQ,
        ST_SCAN,
        ST_DRAIN,
        ST_SQRT,
        ST_EMIT
    } state_t;

    // Status from the distance pipe toward the sorter.
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DSQ_W-1:0]  dsq;
    } cand_t;

endpackage

>>> design/apknn_dist.sv
// ============================================================================
// apknn_dist
// Squared Euclidean distance pipe: diff stage, square stage, sum stage.
// ============================================================================
module apknn_dist
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [apknn_pkg::IDX_W-1:0]         in_idx,
    input  logic [3*apknn_pkg::COORD_W-1:0]     qpt,
    input  logic [3*apknn_pkg::COORD_W-1:0]     cpt,
    output apknn_pkg::cand_t                    cand
);
    localparam int CW = apknn_pkg::COORD_W;

    logic                            v1_reg, v2_reg, v3_reg;
    logic [apknn_pkg::IDX_W-1:0]     i1_reg, i2_reg, i3_reg;
    logic [CW-1:0]                   d_reg  [3];
    logic [2*CW-1:0]                 s_reg  [3];
    logic [apknn_pkg::DSQ_W-1:0]     sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            // absolute difference
            if (qpt[c*CW +: CW] >= cpt[c*CW +: CW])
                d_reg[c] <= qpt[c*CW +: CW] - cpt[c*CW +: CW];
            else
                d_reg[c] <= cpt[c*CW +: CW] - qpt[c*CW +: CW];
            s_reg[c] <= d_reg[c] * d_reg[c];
        end
        sum_reg <= {2'b00, s_reg[0]} + {2'b00, s_reg[1]} + {2'b00, s_reg[2]};
        i1_reg  <= in_idx;
        i2_reg  <= i1_reg;
        i3_reg  <= i2_reg;
    end

    assign cand.valid = v3_reg;
    assign cand.idx   = i3_reg;
    assign cand.dsq   = sum_reg;
endmodule

>>> design/apknn_sqrt.sv
// ============================================================================
// apknn_sqrt
// Bit-serial floor square root, one result bit per cycle.
// ============================================================================
module apknn_sqrt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [apknn_pkg::DSQ_W-1:0]       value,
    output logic                              done,
    output logic [apknn_pkg::DIST_W-1:0]      root
);
    localparam int RW = apknn_pkg::DIST_W;
    localparam int VW = 2 * RW;   // 34, matches DSQ_W

    logic [VW-1:0]          rem_reg;
    logic [RW-1:0]          res_reg;
    logic [VW-1:0]          src_reg;
    logic [4:0]             cnt_reg;
    logic                   busy_reg;
    logic [VW-1:0]          rem_sh;
    logic [VW-1:0]          trial;

    assign rem_sh = {rem_reg[VW-3:0], src_reg[VW-1 -: 2]};
    assign trial  = {{(VW-RW-2){1'b0}}, res_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(RW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            src_reg <= value;
            rem_reg <= '0;
            res_reg <= '0;
        end
        else if (busy_reg)
        begin
            src_reg <= {src_reg[VW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg <= rem_sh - trial;
                res_reg <= {res_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                res_reg <= {res_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign root = res_reg;
endmodule

>>> design/all_points_k_nearest_neighbors.sv
// ============================================================================
// all_points_k_nearest_neighbors
// Brute-force K-nearest-neighbor search over a point memory.
// ============================================================================
// Write: accepted while idle, busy stays low. Query: busy through load, scan
// and drain (count saturated at MAX_POINTS), then per neighbor found: root
// start, the root bits, done, emit. Scan is bound by the single read port
// of the point memory; output by the bit-serial root unit. The receiver
// cannot stall.
// Reset clears control and point_count (128); point memory is not cleared.
module all_points_k_nearest_neighbors #(
    parameter int MAX_POINTS = 128,
    parameter int NEIGHBORS  = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  apknn_pkg::cmd_t               cmd_in,
    output logic                          busy,
    output logic                          result_valid,
    output apknn_pkg::result_t            result,
    input  logic                          cfg_we,
    input  logic [apknn_pkg::CNT_W-1:0]   cfg_data
);
    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int JW  = AW + 1;               // counts up to MAX_POINTS
    localparam int KW  = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int FW  = $clog2(NEIGHBORS + 1);
    localparam int CW3 = 3 * apknn_pkg::COORD_W;
    localparam int IW  = apknn_pkg::IDX_W;
    localparam int DW  = apknn_pkg::DSQ_W;

    // ---------------- point memory, one write / one read port -------------
    logic [CW3-1:0] mem [MAX_POINTS];
    logic [CW3-1:0] rd_data_reg;
    logic [AW-1:0]  rd_addr;

    // ---------------- control ----------------
    apknn_pkg::state_t state_reg, state_next;
    logic [apknn_pkg::CNT_W-1:0] count_reg;
    logic [JW-1:0]   j_reg;            // scan address
    logic [JW-1:0]   lim_reg;          // effective count
    logic [IW-1:0]   q_reg;            // query index
    logic [CW3-1:0]  qpt_reg;
    logic            rd_v_reg;         // read data valid (candidate)
    logic [IW-1:0]   rd_i_reg;
    logic [2:0]      drain_reg;
    logic [KW-1:0]   k_reg;
    logic [FW-1:0]   filled_reg;
    logic            sq_start, sq_done;
    logic [apknn_pkg::DIST_W-1:0] root;
    logic            sq_go_reg;

    logic [IW-1:0]   bi_reg [NEIGHBORS];
    logic [DW-1:0]   bd_reg [NEIGHBORS];

    apknn_pkg::cand_t cand;

    logic accept;
    assign accept = start && !busy;

    logic index_ok;
    assign index_ok = (32'(cmd_in.point_index) < MAX_POINTS);

    always_ff @(posedge clk)
    begin
        if (accept && cmd_in.cmd == apknn_pkg::CMD_WRITE && index_ok)
            mem[AW'(cmd_in.point_index)] <= {cmd_in.coord_x, cmd_in.coord_y, cmd_in.coord_z};
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apknn_pkg::ST_IDLE:
                if (accept && cmd_in.cmd == apknn_pkg::CMD_QUERY && index_ok)
                    state_next = apknn_pkg::ST_LOADQ;
            apknn_pkg::ST_LOADQ:
                state_next = apknn_pkg::ST_SCAN;
            apknn_pkg::ST_SCAN:
                if (j_reg >= lim_reg)
                    state_next = apknn_pkg::ST_DRAIN;
            apknn_pkg::ST_DRAIN:
                if (drain_reg == 3'd0)
                    state_next = (filled_reg == '0) ? apknn_pkg::ST_IDLE
                                                    : apknn_pkg::ST_SQRT;
            apknn_pkg::ST_SQRT:
                if (sq_done)
                    state_next = apknn_pkg::ST_EMIT;
            apknn_pkg::ST_EMIT:
                state_next = (FW'(k_reg) + FW'(1) >= filled_reg) ? apknn_pkg::ST_IDLE
                                                               : apknn_pkg::ST_SQRT;
            default:
                state_next = apknn_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        busy     = (state_reg != apknn_pkg::ST_IDLE);
        rd_addr  = AW'(q_reg);
        sq_start = 1'b0;
        unique case (state_reg)
            apknn_pkg::ST_IDLE:  rd_addr = AW'(cmd_in.point_index);
            apknn_pkg::ST_LOADQ: rd_addr = j_reg[AW-1:0];
            apknn_pkg::ST_SCAN:  rd_addr = j_reg[AW-1:0];
            apknn_pkg::ST_SQRT:  sq_start = sq_go_reg;
            default:             rd_addr = AW'(q_reg);
        endcase
    end

    // insertion position: count entries the candidate does not beat
    logic [FW-1:0] pos;
    always_comb
    begin
        pos = '0;
        for (int m = 0; m < NEIGHBORS; m++)
            if (FW'(m) < filled_reg && !(cand.dsq < bd_reg[m]))
                pos = pos + FW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= apknn_pkg::ST_IDLE;
            count_reg    <= apknn_pkg::CNT_W'(128);
            filled_reg   <= '0;
            rd_v_reg     <= 1'b0;
            drain_reg    <= '0;
            k_reg        <= '0;
            sq_go_reg    <= 1'b0;
            result_valid <= 1'b0;
            j_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            result_valid <= (state_reg == apknn_pkg::ST_EMIT);
            sq_go_reg    <= (state_reg == apknn_pkg::ST_DRAIN)
                            || (state_reg == apknn_pkg::ST_EMIT);
            // flag the address issued now; its data lands in rd_data_reg
            // together with this flag
            rd_v_reg     <= (state_reg == apknn_pkg::ST_LOADQ
                             || state_reg == apknn_pkg::ST_SCAN)
                            && j_reg != JW'(q_reg) && j_reg < lim_reg;
            if (cfg_we)
                count_reg <= cfg_data;
            unique case (state_reg)
                apknn_pkg::ST_IDLE:
                begin
                    j_reg      <= '0;
                    filled_reg <= '0;
                    k_reg      <= '0;
                end
                apknn_pkg::ST_LOADQ:
                    j_reg <= j_reg + JW'(1);
                apknn_pkg::ST_SCAN:
                begin
                    j_reg     <= j_reg + JW'(1);
                    drain_reg <= 3'd4;
                end
                apknn_pkg::ST_DRAIN:
                    drain_reg <= drain_reg - 3'd1;
                apknn_pkg::ST_SQRT:
                    ;
                apknn_pkg::ST_EMIT:
                    k_reg <= k_reg + KW'(1);
                default: ;
            endcase
            if (cand.valid && 32'(pos) < NEIGHBORS && 32'(filled_reg) < NEIGHBORS)
                filled_reg <= filled_reg + FW'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg   <= cmd_in.point_index;
            lim_reg <= (32'(count_reg) > MAX_POINTS) ? JW'(MAX_POINTS) : JW'(count_reg);
        end
        if (state_reg == apknn_pkg::ST_LOADQ)
            qpt_reg <= rd_data_reg;
        rd_i_reg <= IW'(j_reg);
        if (cand.valid && 32'(pos) < NEIGHBORS)
        begin
            for (int m = NEIGHBORS - 1; m > 0; m--)
                if (FW'(m) > pos)
                begin
                    bi_reg[m] <= bi_reg[m-1];
                    bd_reg[m] <= bd_reg[m-1];
                end
            bi_reg[KW'(pos)] <= cand.idx;
            bd_reg[KW'(pos)] <= cand.dsq;
        end
        if (state_reg == apknn_pkg::ST_EMIT)
        begin
            result.neighbor_index <= bi_reg[k_reg];
            result.distance       <= root;
            result.rank           <= apknn_pkg::RANK_W'(k_reg);
            result.last           <= (FW'(k_reg) + FW'(1) >= filled_reg);
        end
    end

    // rd_v_reg and rd_i_reg are registered from the address issued in the
    // same cycle as the read, so they line up with rd_data_reg.
    apknn_dist u_dist
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_v_reg),
        .in_idx   (rd_i_reg),
        .qpt      (qpt_reg),
        .cpt      (rd_data_reg),
        .cand     (cand)
    );

    apknn_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (bd_reg[k_reg]),
        .done  (sq_done),
        .root  (root)
    );

    // ---------------- assertions ----------------
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg) == apknn_pkg::ST_EMIT)
        else $error("result strobe outside emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(filled_reg) <= NEIGHBORS)
        else $error("best list overfilled");
    assert property (@(posedge clk) disable iff (!rst_n)
        cand.valid |-> state_reg == apknn_pkg::ST_SCAN || state_reg == apknn_pkg::ST_DRAIN)
        else $error("candidate outside scan");
endmodule
